[hw/rtl/cardl_pkg.sv]
// ============================================================================
// cardl_pkg
// Shared types and constants of the cancelling add/remove delta list unit.
// ============================================================================
package cardl_pkg;

    // Width of the read position field of a command item.
    localparam int INDEX_BITS = 5;

    // Command codes of an input item.
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    // Per-list control for the cycle in which a command executes.
    typedef struct packed {
        logic clear;   // empty the list
        logic cancel;  // delete the first entry equal to the key, if any
        logic append;  // append the key unless the list is full
    } t_list_ctl;

    // Per-cell control, already qualified by the list.
    typedef struct packed {
        logic cancel;  // close the gap left by the first match
        logic append;  // the cell at the fill position takes the key
    } t_cell_ctl;

endpackage

[hw/rtl/cardl_cell.sv]
// ============================================================================
// cardl_cell
// One list position: holds an entry, compares it with the key, and takes
// the entry of its right neighbor when an earlier or own match is deleted.
// ============================================================================
module cardl_cell #(
    parameter int POS          = 0,
    parameter int CW           = 6,
    parameter int CMPW         = 6,
    parameter int FEATURE_BITS = 16
) (
    input  logic                            i_clk,
    input  cardl_pkg::t_cell_ctl            i_ctl,
    input  logic [CW-1:0]                   i_fill,
    input  logic [FEATURE_BITS-1:0]         i_key,
    input  logic [cardl_pkg::INDEX_BITS-1:0] i_index,
    input  logic                            i_hit,
    input  logic [FEATURE_BITS-1:0]         i_next_entry,
    output logic                            o_hit,
    output logic [FEATURE_BITS-1:0]         o_entry,
    output logic [FEATURE_BITS-1:0]         o_rd_entry
);

    localparam logic [CMPW-1:0] POS_W = CMPW'(POS);

    logic [FEATURE_BITS-1:0] r_entry;
    logic [FEATURE_BITS-1:0] n_entry;
    logic                    occupied;
    logic                    at_fill;
    logic                    rd_sel;
    logic                    match;

    // The cell holds a live entry only below the list's fill count.
    assign occupied = POS_W < CMPW'(i_fill);
    assign at_fill  = POS_W == CMPW'(i_fill);
    assign rd_sel   = POS_W == CMPW'(i_index);

    // The hit flag ripples to the right: set from the first match onward.
    assign match = occupied && (r_entry == i_key);
    assign o_hit = i_hit | match;

    // Append writes the key; a deletion shifts later entries down by one.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.append && at_fill) begin
            n_entry = i_key;
        end else if (i_ctl.cancel && o_hit) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry    = r_entry;
    assign o_rd_entry = (rd_sel && occupied) ? r_entry : '0;

endmodule

[hw/rtl/cardl_list.sv]
// ============================================================================
// cardl_list
// One ordered list: a row of cells with a shared fill counter, first-match
// search, gap closing, append at the tail and read at an index.
// ============================================================================
module cardl_list #(
    parameter int LIST_DEPTH   = 32,
    parameter int FEATURE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cardl_pkg::t_list_ctl             i_ctl,
    input  logic [FEATURE_BITS-1:0]          i_key,
    input  logic [cardl_pkg::INDEX_BITS-1:0] i_index,
    output logic                             o_found,
    output logic                             o_full,
    output logic [$clog2(LIST_DEPTH+1)-1:0]  o_fill_next,
    output logic                             o_rd_ok,
    output logic [FEATURE_BITS-1:0]          o_rd_entry
);

    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > cardl_pkg::INDEX_BITS) ? CW : cardl_pkg::INDEX_BITS;

    logic [CW-1:0]           r_fill;
    logic [CW-1:0]           n_fill;
    logic [LIST_DEPTH:0]     hit;
    logic [FEATURE_BITS-1:0] entry   [LIST_DEPTH];
    logic [FEATURE_BITS-1:0] rd_part [LIST_DEPTH];
    cardl_pkg::t_cell_ctl    cell_ctl;

    assign o_full  = r_fill == CW'(LIST_DEPTH);
    assign o_found = hit[LIST_DEPTH];

    // Qualify the list command for the cells.
    assign cell_ctl.cancel = i_ctl.cancel && !i_ctl.clear;
    assign cell_ctl.append = i_ctl.append && !i_ctl.clear && !o_full;

    // The search chain enters the first cell with no hit.
    assign hit[0] = 1'b0;

    // Row of cells; the last one has no right neighbor and keeps its entry.
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [FEATURE_BITS-1:0] next_entry;
        if (g == LIST_DEPTH - 1) begin : g_last
            assign next_entry = entry[g];
        end else begin : g_mid
            assign next_entry = entry[g+1];
        end

        cardl_cell #(
            .POS          (g),
            .CW           (CW),
            .CMPW         (CMPW),
            .FEATURE_BITS (FEATURE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_fill       (r_fill),
            .i_key        (i_key),
            .i_index      (i_index),
            .i_hit        (hit[g]),
            .i_next_entry (next_entry),
            .o_hit        (hit[g+1]),
            .o_entry      (entry[g]),
            .o_rd_entry   (rd_part[g])
        );
    end

    // Only the selected, occupied cell drives a nonzero read value.
    always_comb begin
        o_rd_entry = '0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            o_rd_entry = o_rd_entry | rd_part[k];
        end
    end

    assign o_rd_ok = CMPW'(i_index) < CMPW'(r_fill);

    // Fill count update.
    always_comb begin
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_ctl.cancel && o_found) begin
            n_fill = r_fill - CW'(1);
        end else if (i_ctl.append && !o_full) begin
            n_fill = r_fill + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_fill_next = n_fill;

endmodule

[hw/rtl/cancelling_add_remove_delta_list_unit.sv]
// ============================================================================
// cancelling_add_remove_delta_list_unit
// Two ordered feature lists where an add cancels a pending remove of the
// same feature and the other way around; clear and indexed read as well.
// ============================================================================
//
//  Channel   Handshake            Fields
//  --------  -------------------  ------------------------------------------
//  command   start / busy         i_func, i_feature, i_index
//  result    o_valid (strobe)     o_added_count, o_removed_count,
//                                 o_total_count, o_added_entry,
//                                 o_removed_entry, o_cancelled, o_error
//
//  An item is taken when start is high and busy is low, and executes in the
//  following cycle, in which busy is high.
//  Its result is strobed on o_valid in the cycle after execution, for one
//  cycle; the receiver cannot stall it. A new item may be taken in that cycle.
//  The search, gap closing and append run in the row of cells of each list,
//  all in the execution cycle.
//  Reset (synchronous, active low) empties both lists; no clearing pass.
//
module cancelling_add_remove_delta_list_unit #(
    parameter int LIST_DEPTH   = 32,
    parameter int FEATURE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_func,
    input  logic [FEATURE_BITS-1:0]          i_feature,
    input  logic [cardl_pkg::INDEX_BITS-1:0] i_index,
    output logic                             o_valid,
    output logic [$clog2(LIST_DEPTH+1)-1:0]  o_added_count,
    output logic [$clog2(LIST_DEPTH+1)-1:0]  o_removed_count,
    output logic [$clog2(LIST_DEPTH+1):0]    o_total_count,
    output logic [FEATURE_BITS-1:0]          o_added_entry,
    output logic [FEATURE_BITS-1:0]          o_removed_entry,
    output logic                             o_cancelled,
    output logic                             o_error
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    // Command registers.
    logic                             r_pend;
    cardl_pkg::t_func                 r_func;
    logic [FEATURE_BITS-1:0]          r_feat;
    logic [cardl_pkg::INDEX_BITS-1:0] r_idx;

    // Result registers.
    logic                    r_valid;
    logic [CW-1:0]           r_add_cnt;
    logic [CW-1:0]           r_rem_cnt;
    logic [CW:0]             r_tot_cnt;
    logic [FEATURE_BITS-1:0] r_add_ent;
    logic [FEATURE_BITS-1:0] r_rem_ent;
    logic                    r_canc;
    logic                    r_err;

    logic [FEATURE_BITS-1:0] n_add_ent;
    logic [FEATURE_BITS-1:0] n_rem_ent;
    logic                    n_canc;
    logic                    n_err;

    cardl_pkg::t_list_ctl    add_ctl;
    cardl_pkg::t_list_ctl    rem_ctl;
    logic                    add_found;
    logic                    rem_found;
    logic                    add_full;
    logic                    rem_full;
    logic [CW-1:0]           add_fill;
    logic [CW-1:0]           rem_fill;
    logic                    add_rd_ok;
    logic                    rem_rd_ok;
    logic [FEATURE_BITS-1:0] add_rd;
    logic [FEATURE_BITS-1:0] rem_rd;

    logic accept;

    assign busy   = r_pend;
    assign accept = start && !r_pend;

    // Capture the command; it executes in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= cardl_pkg::t_func'(i_func);
            r_feat <= i_feature;
            r_idx  <= i_index;
        end
    end

    // Decode: each list is told what to do, and the result is formed.
    always_comb begin
        add_ctl   = '0;
        rem_ctl   = '0;
        n_add_ent = '0;
        n_rem_ent = '0;
        n_canc    = 1'b0;
        n_err     = 1'b0;
        if (r_pend) begin
            case (r_func)
                cardl_pkg::FUNC_CLEAR: begin
                    add_ctl.clear = 1'b1;
                    rem_ctl.clear = 1'b1;
                end
                cardl_pkg::FUNC_ADD: begin
                    rem_ctl.cancel = 1'b1;
                    add_ctl.append = !rem_found;
                    n_canc         = rem_found;
                    n_err          = !rem_found && add_full;
                end
                cardl_pkg::FUNC_REMOVE: begin
                    add_ctl.cancel = 1'b1;
                    rem_ctl.append = !add_found;
                    n_canc         = add_found;
                    n_err          = !add_found && rem_full;
                end
                cardl_pkg::FUNC_READ: begin
                    n_add_ent = add_rd;
                    n_rem_ent = rem_rd;
                    n_err     = !(add_rd_ok && rem_rd_ok);
                end
                default: begin
                    n_err = 1'b0;
                end
            endcase
        end
    end

    // Added list: cancelled by removes, appended by adds.
    cardl_list #(
        .LIST_DEPTH   (LIST_DEPTH),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_added (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (add_ctl),
        .i_key       (r_feat),
        .i_index     (r_idx),
        .o_found     (add_found),
        .o_full      (add_full),
        .o_fill_next (add_fill),
        .o_rd_ok     (add_rd_ok),
        .o_rd_entry  (add_rd)
    );

    // Removed list: cancelled by adds, appended by removes.
    cardl_list #(
        .LIST_DEPTH   (LIST_DEPTH),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_removed (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (rem_ctl),
        .i_key       (r_feat),
        .i_index     (r_idx),
        .o_found     (rem_found),
        .o_full      (rem_full),
        .o_fill_next (rem_fill),
        .o_rd_ok     (rem_rd_ok),
        .o_rd_entry  (rem_rd)
    );

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_pend;
        end
    end

    // Result payload, loaded in the execution cycle.
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_add_cnt <= add_fill;
            r_rem_cnt <= rem_fill;
            r_tot_cnt <= {1'b0, add_fill} + {1'b0, rem_fill};
            r_add_ent <= n_add_ent;
            r_rem_ent <= n_rem_ent;
            r_canc    <= n_canc;
            r_err     <= n_err;
        end
    end

    assign o_valid         = r_valid;
    assign o_added_count   = r_add_cnt;
    assign o_removed_count = r_rem_cnt;
    assign o_total_count   = r_tot_cnt;
    assign o_added_entry   = r_add_ent;
    assign o_removed_entry = r_rem_ent;
    assign o_cancelled     = r_canc;
    assign o_error         = r_err;

    // Every executed command yields exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("executed command produced no result");

    // A result never appears without an executed command.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without command");

    // A cancellation cannot also report an error.
    a_cancel_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cancelled) |-> !o_error)
        else $error("cancelled result flagged as error");

    // Counts stay within the list depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_added_count <= CW'(LIST_DEPTH) &&
                     o_removed_count <= CW'(LIST_DEPTH)))
        else $error("list count beyond depth");

endmodule
